FILE: sv/egd_pkg.sv
package egd_pkg;

   // field widths
   localparam int CODE_W = 32;
   localparam int SUF_W  = 31;
   localparam int CNT_W  = 5;
   localparam int BYTE_W = 8;
   localparam int IDX_W  = 3;
   localparam int STS_W  = 2;

   // result status codes
   localparam logic [STS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STS_W-1:0] ST_LONG  = 2'd1;
   localparam logic [STS_W-1:0] ST_TRUNC = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic load;        // take a new byte
      logic bit_step;    // consume one bit
      logic trunc_step;  // stream-end check
      logic last_push;   // move the held result out, marked last
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic bit_emit;    // current bit finishes a result
      logic trunc_emit;  // stream end with a partial code
      logic pend_valid;  // a result is held back
      logic out_free;    // output register can take a result this cycle
      logic bit_last;    // current bit is the least significant one
   } sts_type;

endpackage

FILE: sv/egd_ctrl.sv
module egd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  egd_pkg::sts_type sts,
   output egd_pkg::cmd_type cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_BITS  = 2'd1;
   localparam logic [1:0] S_TRUNC = 2'd2;
   localparam logic [1:0] S_LAST  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       blocked;

   // a new result needs the held one moved out first
   assign blocked = sts.pend_valid && !sts.out_free;

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_tready     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_BITS;
            end
         end
         S_BITS: begin
            if (!(sts.bit_emit && blocked)) begin
               cmd.bit_step = 1'b1;
               if (sts.bit_last) begin
                  state_in = S_TRUNC;
               end
            end
         end
         S_TRUNC: begin
            if (!(sts.trunc_emit && blocked)) begin
               cmd.trunc_step = 1'b1;
               state_in       = S_LAST;
            end
         end
         S_LAST: begin
            if (!sts.pend_valid) begin
               state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.last_push = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/egd_datapath.sv
module egd_datapath #(
   parameter int MAX_PREFIX = 31
) (
   input  logic                         clock,
   input  logic                         reset,
   input  egd_pkg::cmd_type             cmd,
   output egd_pkg::sts_type             sts,
   input  logic [egd_pkg::BYTE_W-1:0]   in_byte,
   input  logic                         in_end,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [egd_pkg::CODE_W-1:0]   rsp_tdata,
   output logic [egd_pkg::STS_W-1:0]    rsp_tuser,
   output logic                         rsp_tlast
);

   localparam logic [egd_pkg::CNT_W-1:0] MaxZeros = egd_pkg::CNT_W'(MAX_PREFIX);

   // code state
   logic                         in_suffix_ff, in_suffix_in;
   logic [egd_pkg::CNT_W-1:0]    zero_cnt_ff, zero_cnt_in;
   logic [egd_pkg::CNT_W-1:0]    suf_left_ff, suf_left_in;
   logic [egd_pkg::SUF_W-1:0]    suf_val_ff, suf_val_in;
   // byte state
   logic [egd_pkg::BYTE_W-1:0]   byte_ff, byte_in;
   logic                         end_ff, end_in;
   logic [egd_pkg::IDX_W-1:0]    bit_idx_ff, bit_idx_in;
   // held result
   logic                         pend_vld_ff, pend_vld_in;
   logic [egd_pkg::CODE_W-1:0]   pend_code_ff, pend_code_in;
   logic [egd_pkg::STS_W-1:0]    pend_sts_ff, pend_sts_in;
   // output register
   logic                         out_vld_ff, out_vld_in;
   logic [egd_pkg::CODE_W-1:0]   out_code_ff, out_code_in;
   logic [egd_pkg::STS_W-1:0]    out_sts_ff, out_sts_in;
   logic                         out_last_ff, out_last_in;

   // per-bit decode results
   logic                         cur_bit;
   logic                         b_emit;
   logic [egd_pkg::CODE_W-1:0]   b_code;
   logic [egd_pkg::STS_W-1:0]    b_sts;
   logic                         b_in_suffix;
   logic [egd_pkg::CNT_W-1:0]    b_zero_cnt;
   logic [egd_pkg::CNT_W-1:0]    b_suf_left;
   logic [egd_pkg::SUF_W-1:0]    b_suf_val;
   logic [egd_pkg::CODE_W-1:0]   base;
   logic                         trunc_emit;
   logic                         ev_valid;
   logic [egd_pkg::CODE_W-1:0]   ev_code;
   logic [egd_pkg::STS_W-1:0]    ev_sts;
   logic                         out_free;

   assign cur_bit    = byte_ff[egd_pkg::BYTE_W-1];
   assign base       = (egd_pkg::CODE_W'(1) << zero_cnt_ff) - egd_pkg::CODE_W'(1);
   assign trunc_emit = end_ff && (in_suffix_ff || (zero_cnt_ff != '0));
   assign out_free   = !out_vld_ff || rsp_tready;

   // decode of the current bit
   always_comb begin
      b_emit      = 1'b0;
      b_code      = '0;
      b_sts       = egd_pkg::ST_OK;
      b_in_suffix = in_suffix_ff;
      b_zero_cnt  = zero_cnt_ff;
      b_suf_left  = suf_left_ff;
      b_suf_val   = suf_val_ff;
      if (!in_suffix_ff) begin
         if (!cur_bit) begin
            if (zero_cnt_ff >= MaxZeros) begin
               b_emit     = 1'b1;
               b_sts      = egd_pkg::ST_LONG;
               b_zero_cnt = '0;
            end else begin
               b_zero_cnt = zero_cnt_ff + egd_pkg::CNT_W'(1);
            end
         end else if (zero_cnt_ff == '0) begin
            // one bit with no zeros: code zero
            b_emit = 1'b1;
         end else begin
            b_in_suffix = 1'b1;
            b_suf_left  = zero_cnt_ff;
            b_suf_val   = '0;
         end
      end else begin
         b_suf_val  = {suf_val_ff[egd_pkg::SUF_W-2:0], cur_bit};
         b_suf_left = suf_left_ff - egd_pkg::CNT_W'(1);
         if (suf_left_ff == egd_pkg::CNT_W'(1)) begin
            b_emit      = 1'b1;
            b_code      = base + {1'b0, b_suf_val};
            b_in_suffix = 1'b0;
            b_zero_cnt  = '0;
            b_suf_left  = '0;
            b_suf_val   = '0;
         end
      end
   end

   // result event from the bit walk or the stream-end check
   always_comb begin
      ev_valid = 1'b0;
      ev_code  = '0;
      ev_sts   = egd_pkg::ST_OK;
      if (cmd.bit_step && b_emit) begin
         ev_valid = 1'b1;
         ev_code  = b_code;
         ev_sts   = b_sts;
      end else if (cmd.trunc_step && trunc_emit) begin
         ev_valid = 1'b1;
         ev_sts   = egd_pkg::ST_TRUNC;
      end
   end

   // next values
   always_comb begin
      in_suffix_in = in_suffix_ff;
      zero_cnt_in  = zero_cnt_ff;
      suf_left_in  = suf_left_ff;
      suf_val_in   = suf_val_ff;
      byte_in      = byte_ff;
      end_in       = end_ff;
      bit_idx_in   = bit_idx_ff;
      pend_vld_in  = pend_vld_ff;
      pend_code_in = pend_code_ff;
      pend_sts_in  = pend_sts_ff;
      out_vld_in   = out_vld_ff && !rsp_tready;
      out_code_in  = out_code_ff;
      out_sts_in   = out_sts_ff;
      out_last_in  = out_last_ff;

      if (cmd.load) begin
         byte_in    = in_byte;
         end_in     = in_end;
         bit_idx_in = '0;
      end

      if (cmd.bit_step) begin
         in_suffix_in = b_in_suffix;
         zero_cnt_in  = b_zero_cnt;
         suf_left_in  = b_suf_left;
         suf_val_in   = b_suf_val;
         byte_in      = {byte_ff[egd_pkg::BYTE_W-2:0], 1'b0};
         bit_idx_in   = bit_idx_ff + egd_pkg::IDX_W'(1);
      end

      // stream end drops any partial code
      if (cmd.trunc_step && end_ff) begin
         in_suffix_in = 1'b0;
         zero_cnt_in  = '0;
         suf_left_in  = '0;
         suf_val_in   = '0;
      end

      // a new result pushes the held one out, not last
      if (ev_valid) begin
         if (pend_vld_ff) begin
            out_vld_in  = 1'b1;
            out_code_in = pend_code_ff;
            out_sts_in  = pend_sts_ff;
            out_last_in = 1'b0;
         end
         pend_vld_in  = 1'b1;
         pend_code_in = ev_code;
         pend_sts_in  = ev_sts;
      end

      // end of byte: held result goes out marked last
      if (cmd.last_push && pend_vld_ff) begin
         out_vld_in  = 1'b1;
         out_code_in = pend_code_ff;
         out_sts_in  = pend_sts_ff;
         out_last_in = 1'b1;
         pend_vld_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_suffix_ff <= 1'b0;
         zero_cnt_ff  <= '0;
         suf_left_ff  <= '0;
         suf_val_ff   <= '0;
         bit_idx_ff   <= '0;
         pend_vld_ff  <= 1'b0;
         out_vld_ff   <= 1'b0;
      end else begin
         in_suffix_ff <= in_suffix_in;
         zero_cnt_ff  <= zero_cnt_in;
         suf_left_ff  <= suf_left_in;
         suf_val_ff   <= suf_val_in;
         bit_idx_ff   <= bit_idx_in;
         pend_vld_ff  <= pend_vld_in;
         out_vld_ff   <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      end_ff       <= end_in;
      pend_code_ff <= pend_code_in;
      pend_sts_ff  <= pend_sts_in;
      out_code_ff  <= out_code_in;
      out_sts_ff   <= out_sts_in;
      out_last_ff  <= out_last_in;
   end

   assign sts.bit_emit   = b_emit;
   assign sts.trunc_emit = trunc_emit;
   assign sts.pend_valid = pend_vld_ff;
   assign sts.out_free   = out_free;
   assign sts.bit_last   = (bit_idx_ff == {egd_pkg::IDX_W{1'b1}});

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_code_ff;
   assign rsp_tuser  = out_sts_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

FILE: sv/exp_golomb_ue_decoder.sv
// Unsigned Exp-Golomb decoder, fed one stream byte per req transaction.
// req channel: tdata[7:0] is the byte, taken from bit 7 down; tlast marks
// the final byte of the stream. rsp channel: one transaction per decoded
// code, prefix error or truncation, in bit order. tdata is the code number
// (zero unless status is ok), tuser the status (0 ok, 1 prefix too long,
// 2 truncated at stream end), tlast flags the final result of that byte.
// The byte is walked one bit per cycle while rsp does not hold it up, then the
// stream-end check runs and the result held back for its last flag is released.
// req_tready is low from the accepted byte until all of this is done and high
// again once the block is idle, so a new byte is taken only after the last one.
// Each result is held back in a register so its last flag is known; it appears on
// rsp after the next result of the byte is found or after the byte ends.
// A stalled rsp stops the bit walk only when a new result needs the
// output register; nothing is lost or repeated.
// Reset clears the code state and both result registers; the block is
// then ready for a byte on the next cycle.
module exp_golomb_ue_decoder #(
   parameter int MAX_PREFIX = 31
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // stream_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] code_num
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast    // last_in_run
);

   egd_pkg::cmd_type cmd;
   egd_pkg::sts_type sts;

   // sequencer
   egd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // bit decoder and result registers
   egd_datapath #(
      .MAX_PREFIX (MAX_PREFIX)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .in_byte    (req_tdata),
      .in_end     (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: sv/egd_checker.sv
module egd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   // error results carry no code number
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != egd_pkg::ST_OK) |-> rsp_tdata == '0)
      else $error("non-ok status with non-zero code number");

   // only defined status codes
   a_sts_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == egd_pkg::ST_OK) || (rsp_tuser == egd_pkg::ST_LONG)
         || (rsp_tuser == egd_pkg::ST_TRUNC))
      else $error("undefined status code");

   // one byte at a time: busy after a transaction
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("byte accepted while previous one in progress");

   // nothing left over after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind exp_golomb_ue_decoder egd_checker u_egd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

FILE: bench/testbench.sv
module testbench;

   localparam int PREFIX_LIMIT = 31;
   localparam int RANDOM_BYTES = 200;
   localparam int SETTLE_CYCLES = 12;
   localparam int LONG_HOLD_CYCLES = 300;

   // one decoded result as it leaves the block
   typedef struct packed {
      logic [31:0] code_num;
      logic [1:0]  status;
      logic        last;
   } ue_result_type;

   // bit-exact model of the decoder plus the queue of results still owed
   class ue_scoreboard;
      ue_result_type pending_codes[$];
      bit         in_suffix;
      bit [4:0]   zero_count;
      bit [4:0]   suffix_left;
      bit [30:0]  suffix_value;
      int         failures;

      function void clear_code();
         in_suffix    = 1'b0;
         zero_count   = '0;
         suffix_left  = '0;
         suffix_value = '0;
      endfunction

      // walk the byte MSB first and queue every result it finishes
      function void accept_byte(bit [7:0] data, bit stream_end);
         ue_result_type found[$];
         ue_result_type r;
         bit         b;
         bit [31:0]  base;
         for (int i = 7; i >= 0; i--) begin
            b = data[i];
            r = '0;
            if (!in_suffix) begin
               if (!b) begin
                  if (zero_count >= 5'(PREFIX_LIMIT)) begin
                     r.status = egd_pkg::ST_LONG;
                     found.push_back(r);
                     zero_count = '0;
                  end else begin
                     zero_count = zero_count + 5'd1;
                  end
               end else if (zero_count == 0) begin
                  r.status = egd_pkg::ST_OK;
                  found.push_back(r);
               end else begin
                  in_suffix    = 1'b1;
                  suffix_left  = zero_count;
                  suffix_value = '0;
               end
            end else begin
               suffix_value = {suffix_value[29:0], b};
               suffix_left  = suffix_left - 5'd1;
               if (suffix_left == 0) begin
                  base       = (32'd1 << zero_count) - 32'd1;
                  r.code_num = base + {1'b0, suffix_value};
                  r.status   = egd_pkg::ST_OK;
                  found.push_back(r);
                  clear_code();
               end
            end
         end
         // partial code at stream end is reported as truncated
         if (stream_end) begin
            if (in_suffix || zero_count != 0) begin
               r = '0;
               r.status = egd_pkg::ST_TRUNC;
               found.push_back(r);
            end
            clear_code();
         end
         if (found.size() > 0) found[found.size()-1].last = 1'b1;
         foreach (found[k]) pending_codes.push_back(found[k]);
      endfunction

      function void report(string what, ue_result_type exp_r, ue_result_type act_r);
         failures++;
         if (failures <= 10)
            $display({"%0t: %s: expected code %0d status %0d last %0d,",
                      " got code %0d status %0d last %0d"},
                     $time, what, exp_r.code_num, exp_r.status, exp_r.last,
                     act_r.code_num, act_r.status, act_r.last);
      endfunction

      function void check_code(logic [31:0] code_num, logic [1:0] status, logic last);
         ue_result_type act_r;
         ue_result_type exp_r;
         act_r = {code_num, status, last};
         if (pending_codes.size() == 0) begin
            report("unexpected result", '0, act_r);
         end else begin
            exp_r = pending_codes.pop_front();
            if (act_r !== exp_r) report("result mismatch", exp_r, act_r);
         end
      endfunction

      function void check_leftover();
         while (pending_codes.size() > 0)
            report("missing result", pending_codes.pop_front(), 'x);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   ue_scoreboard sb = new();
   bit  hold_request = 1'b0;
   int  burst_left = 0;
   int  bytes_sent = 0;
   bit  stream_bits[$];

   exp_golomb_ue_decoder #(.MAX_PREFIX(PREFIX_LIMIT)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // hard stop in case the block hangs
   initial begin
      #1600000;
      $display("exp_golomb_ue_decoder regression: fail");
      $finish;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_code(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // receiver: phases of full rate, random stalls and heavy stalls, plus one long hold-off
   initial begin
      int phase_left;
      int mode;
      phase_left = 0;
      mode = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else begin
            if (phase_left == 0) begin
               phase_left = $urandom_range(10, 60);
               mode = $urandom_range(0, 2);
            end
            phase_left--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // one req transaction, with burst/gap pacing in front of it
   task automatic send_byte(input bit [7:0] data, input bit stream_end);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= stream_end;
      do @(posedge clock); while (!req_tready);
      sb.accept_byte(data, stream_end);
      bytes_sent++;
   endtask

   // stop offering bytes until every owed result has come out
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_codes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // append one code: mostly well-formed (n zeros, a one, n suffix bits), sometimes an over-long prefix
   task automatic push_code();
      int       n;
      int       r;
      bit [30:0] suffix;
      r = $urandom_range(0, 24);
      if (r == 0) begin
         // over-long prefix: exactly one error, count restarts from zero
         repeat (PREFIX_LIMIT + 1) stream_bits.push_back(1'b0);
      end else begin
         if (r < 15) n = $urandom_range(0, 3);
         else if (r < 23) n = $urandom_range(4, 12);
         else n = $urandom_range(13, PREFIX_LIMIT);
         suffix = 31'($urandom);
         repeat (n) stream_bits.push_back(1'b0);
         stream_bits.push_back(1'b1);
         for (int i = n - 1; i >= 0; i--) stream_bits.push_back(suffix[i]);
      end
   endtask

   // send whole bytes from the bit queue; optionally close the stream
   task automatic flush_bits(input bit close_stream);
      bit [7:0] b;
      if (close_stream) begin
         while (stream_bits.size() % 8 != 0)
            stream_bits.push_back(1'($urandom_range(0, 1)));
         if (stream_bits.size() == 0)
            repeat (8) stream_bits.push_back(1'($urandom_range(0, 1)));
      end
      while (stream_bits.size() >= 8) begin
         for (int i = 7; i >= 0; i--) b[i] = stream_bits.pop_front();
         send_byte(b, close_stream && stream_bits.size() == 0);
      end
   endtask

   // stimulus
   initial begin
      int  rand_start;
      int  choice;
      bit  held;
      bit  paused;
      held = 1'b0;
      paused = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed: eight zero-length codes in one byte
      send_byte(8'hFF, 1'b0);
      // longest legal prefix with an all-ones suffix: largest code number
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      // prefix one zero too long, then truncation inside a prefix
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b1);
      // truncation while reading the suffix
      send_byte(8'h01, 1'b1);
      // stream end with nothing pending
      send_byte(8'hFF, 1'b1);
      // a byte that finishes nothing, then codes spanning a boundary
      send_byte(8'h00, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'h00, 1'b1);
      wait_drained();

      // random: mostly well-formed code streams, some noise bytes and stream ends
      rand_start = bytes_sent;
      while (bytes_sent - rand_start < RANDOM_BYTES) begin
         if (!held && bytes_sent - rand_start >= 70) begin
            hold_request = 1'b1;
            held = 1'b1;
         end
         if (!paused && bytes_sent - rand_start >= 140) begin
            wait_drained();
            paused = 1'b1;
         end
         choice = $urandom_range(0, 9);
         if (choice == 0) begin
            flush_bits(1'b0);
            stream_bits.delete();
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         end else if (choice == 9) begin
            flush_bits(1'b1);
         end else begin
            repeat ($urandom_range(1, 6)) push_code();
            flush_bits(1'b0);
         end
      end
      flush_bits(1'b1);
      wait_drained();

      sb.check_leftover();
      if (sb.failures == 0)
         $display("exp_golomb_ue_decoder regression: pass");
      else
         $display("exp_golomb_ue_decoder regression: fail");
      $finish;
   end

endmodule
